// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// check that a condition never holds outside reset
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

`endif

// ===== rtl/pgss_pkg.sv =====
`default_nettype none

package pgss_pkg;

    localparam int FUNC_W     = 2;
    localparam int CHIP_IN_W  = 2;
    localparam int CHAN_W     = 4;
    localparam int LEVEL_W    = 12;
    localparam int WORD_W     = 24;
    localparam int PAIR_W     = 3;
    localparam int CHIP_IDX_W = 3;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_SET   = 2'd0,
        FUNC_GET   = 2'd1,
        FUNC_SHIFT = 2'd2
    } func_t;

    typedef struct packed {
        logic                  wr_en;
        logic                  rd_en;
        logic                  rd_get;
        logic                  rd_final;
        logic                  bank;
        logic                  chip_ok;
        logic [CHIP_IDX_W-1:0] chip;
        logic [PAIR_W-1:0]     pair;
        logic [LEVEL_W-1:0]    level;
    } pgss_cmd_t;

    typedef struct packed {
        logic rd_room;
    } pgss_stat_t;

endpackage

`default_nettype wire

// ===== rtl/pgss_ctrl.sv =====
`default_nettype none

module pgss_ctrl
    import pgss_pkg::*;
#(
    parameter int CHIPS = 3
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [FUNC_W-1:0]    s_func,
    input  wire logic [CHIP_IN_W-1:0] s_chip,
    input  wire logic [CHAN_W-1:0]    s_channel,
    input  wire logic [LEVEL_W-1:0]   s_level,
    input  wire pgss_stat_t           stat,
    output pgss_cmd_t                 cmd
);

    localparam int CHIP_W = (CHIPS > 1) ? $clog2(CHIPS) : 1;

    typedef enum logic {
        ST_IDLE,
        ST_SHIFT
    } state_t;

    state_t              state_reg, state_next;
    logic [CHIP_W-1:0]   chip_cnt_reg, chip_cnt_next;
    logic [PAIR_W-1:0]   pair_cnt_reg, pair_cnt_next;
    logic                accept;
    logic                chip_ok;

    assign s_ready = (state_reg == ST_IDLE) && stat.rd_room;
    assign accept  = s_valid && s_ready;
    assign chip_ok = 32'(s_chip) < CHIPS;

    always_comb begin
        state_next    = state_reg;
        chip_cnt_next = chip_cnt_reg;
        pair_cnt_next = pair_cnt_reg;
        cmd           = '0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.chip    = CHIP_IDX_W'(s_chip);
                cmd.pair    = s_channel[CHAN_W-1:1];
                cmd.bank    = s_channel[0];
                cmd.level   = s_level;
                cmd.chip_ok = chip_ok;
                if (accept) begin
                    unique case (func_t'(s_func))
                        FUNC_SET: begin
                            cmd.wr_en = chip_ok;
                        end
                        FUNC_GET: begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_get = 1'b1;
                        end
                        FUNC_SHIFT: begin
                            state_next    = ST_SHIFT;
                            chip_cnt_next = CHIP_W'(CHIPS - 1);
                            pair_cnt_next = '1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SHIFT: begin
                cmd.chip     = CHIP_IDX_W'(chip_cnt_reg);
                cmd.pair     = pair_cnt_reg;
                cmd.chip_ok  = 1'b1;
                cmd.rd_final = (chip_cnt_reg == '0) && (pair_cnt_reg == '0);
                if (stat.rd_room) begin
                    cmd.rd_en = 1'b1;
                    if (pair_cnt_reg == '0) begin
                        pair_cnt_next = '1;
                        if (chip_cnt_reg == '0) begin
                            state_next = ST_IDLE;
                        end else begin
                            chip_cnt_next = chip_cnt_reg - 1'b1;
                        end
                    end else begin
                        pair_cnt_next = pair_cnt_reg - 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            chip_cnt_reg <= '0;
            pair_cnt_reg <= '0;
        end else begin
            state_reg    <= state_next;
            chip_cnt_reg <= chip_cnt_next;
            pair_cnt_reg <= pair_cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pgss_dp.sv =====
`default_nettype none

module pgss_dp
    import pgss_pkg::*;
#(
    parameter int CHIPS = 3
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire pgss_cmd_t        cmd,
    output pgss_stat_t            stat,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [LEVEL_W-1:0]    m_read_level,
    output logic [WORD_W-1:0]     m_shift_word,
    output logic                  m_shift_valid,
    output logic                  m_final_group
);

    localparam int ROWS  = CHIPS * 8;
    localparam int ROW_W = $clog2(ROWS);

    logic [LEVEL_W-1:0] mem_even [ROWS];
    logic [LEVEL_W-1:0] mem_odd  [ROWS];
    logic               vld_even_reg [ROWS];
    logic               vld_odd_reg  [ROWS];

    logic [ROW_W-1:0]   row;

    logic [LEVEL_W-1:0] rd_even_reg, rd_odd_reg;
    logic               ok_even_reg, ok_odd_reg;
    logic               stg_valid_reg, stg_get_reg, stg_final_reg, stg_bank_reg;
    logic               stage_move;

    logic [LEVEL_W-1:0] lvl_even, lvl_odd;

    logic               m_valid_reg;
    logic [LEVEL_W-1:0] read_level_reg;
    logic [WORD_W-1:0]  shift_word_reg;
    logic               shift_valid_reg, final_group_reg;

    assign row          = ROW_W'({cmd.chip, cmd.pair});
    assign stage_move   = stg_valid_reg && (!m_valid_reg || m_ready);
    assign stat.rd_room = !stg_valid_reg || stage_move;

    always_ff @(posedge aclk) begin
        if (cmd.wr_en && !cmd.bank) begin
            mem_even[row] <= cmd.level;
        end
        if (cmd.rd_en) begin
            rd_even_reg <= mem_even[row];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_en && cmd.bank) begin
            mem_odd[row] <= cmd.level;
        end
        if (cmd.rd_en) begin
            rd_odd_reg <= mem_odd[row];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ROWS; i++) begin
                vld_even_reg[i] <= 1'b0;
                vld_odd_reg[i]  <= 1'b0;
            end
        end else if (cmd.wr_en) begin
            if (cmd.bank) begin
                vld_odd_reg[row] <= 1'b1;
            end else begin
                vld_even_reg[row] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_valid_reg <= 1'b0;
        end else if (cmd.rd_en) begin
            stg_valid_reg <= 1'b1;
        end else if (stage_move) begin
            stg_valid_reg <= 1'b0;
        end
        if (cmd.rd_en) begin
            ok_even_reg   <= cmd.chip_ok && vld_even_reg[row];
            ok_odd_reg    <= cmd.chip_ok && vld_odd_reg[row];
            stg_get_reg   <= cmd.rd_get;
            stg_final_reg <= cmd.rd_final;
            stg_bank_reg  <= cmd.bank;
        end
    end

    assign lvl_even = ok_even_reg ? rd_even_reg : '0;
    assign lvl_odd  = ok_odd_reg  ? rd_odd_reg  : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (stage_move) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (stage_move) begin
            if (stg_get_reg) begin
                read_level_reg  <= stg_bank_reg ? lvl_odd : lvl_even;
                shift_word_reg  <= '0;
                shift_valid_reg <= 1'b0;
                final_group_reg <= 1'b0;
            end else begin
                read_level_reg  <= '0;
                shift_word_reg  <= {lvl_odd, lvl_even};
                shift_valid_reg <= 1'b1;
                final_group_reg <= stg_final_reg;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_read_level  = read_level_reg;
    assign m_shift_word  = shift_word_reg;
    assign m_shift_valid = shift_valid_reg;
    assign m_final_group = final_group_reg;

endmodule

`default_nettype wire

// ===== rtl/packed_grayscale_store_shifter.sv =====
// channel | direction | beat fields
// s_      | in        | s_func, s_chip, s_channel, s_level
// m_      | out       | m_read_level, m_shift_word, m_shift_valid, m_final_group
//
// Set: no result. Get: one result, held first in the read stage and then in the
// output register. Shift: CHIPS*8 results at one per cycle while m_ready stays
// high; one read port on each of the even and odd channel banks sets that figure.
// Reset clears the per-row valid bits; the store reads zero after it.
// A stalled result holds in the output register while the read stage holds one more.
`default_nettype none

`include "assert_macros.svh"

module packed_grayscale_store_shifter
    import pgss_pkg::*;
#(
    parameter int CHIPS = 3
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [FUNC_W-1:0]    s_func,
    input  wire logic [CHIP_IN_W-1:0] s_chip,
    input  wire logic [CHAN_W-1:0]    s_channel,
    input  wire logic [LEVEL_W-1:0]   s_level,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [LEVEL_W-1:0]        m_read_level,
    output logic [WORD_W-1:0]         m_shift_word,
    output logic                      m_shift_valid,
    output logic                      m_final_group
);

    pgss_cmd_t  cmd;
    pgss_stat_t stat;

    pgss_ctrl #(
        .CHIPS(CHIPS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_func   (s_func),
        .s_chip   (s_chip),
        .s_channel(s_channel),
        .s_level  (s_level),
        .stat     (stat),
        .cmd      (cmd)
    );

    pgss_dp #(
        .CHIPS(CHIPS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_level (m_read_level),
        .m_shift_word (m_shift_word),
        .m_shift_valid(m_shift_valid),
        .m_final_group(m_final_group)
    );

    `ASSERT_NEVER(a_final_only_on_shift, m_valid && m_final_group && !m_shift_valid, "final beat without shift data")
    `ASSERT_CLK(a_get_word_zero, (m_valid && !m_shift_valid) |-> (m_shift_word == '0), "get beat carries shift data")
    `ASSERT_CLK(a_shift_blocks_input, (s_valid && s_ready && (s_func == FUNC_SHIFT)) |=> !s_ready, "input taken during shift")

endmodule

`default_nettype wire
